// ===== sv/ethernet_header_classifier_macros.svh =====
// assertion helpers shared by the classifier modules
// both expect clk and arst_n in the scope where they are used
`ifndef ETHERNET_HEADER_CLASSIFIER_MACROS_SVH
`define ETHERNET_HEADER_CLASSIFIER_MACROS_SVH

// consequent checked in the same cycle
`define EHC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define EHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ehc_pkg.sv =====
package ehc_pkg;

	// width of the frame byte counter
	localparam int POSITION_BITS = 16;

	localparam logic [15:0] ET_IPV4 = 16'h0800;
	localparam logic [15:0] ET_IPV6 = 16'h86DD;
	localparam logic [15:0] ET_ARP  = 16'h0806;

	localparam logic [7:0] PROTO_ICMP   = 8'd1;
	localparam logic [7:0] PROTO_IGMP   = 8'd2;
	localparam logic [7:0] PROTO_TCP    = 8'd6;
	localparam logic [7:0] PROTO_UDP    = 8'd17;
	localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

	localparam logic [7:0] ICMP6_MLD_QUERY  = 8'd130;
	localparam logic [7:0] ICMP6_MLD_REPORT = 8'd131;
	localparam logic [7:0] ICMP6_NDP_RS     = 8'd133;
	localparam logic [7:0] ICMP6_NDP_RA     = 8'd134;
	localparam logic [7:0] ICMP6_NDP_NS     = 8'd135;
	localparam logic [7:0] ICMP6_NDP_NA     = 8'd136;

	// ethernet header length and ipv4 header word size in bytes
	localparam int ETH_HDR_LEN = 14;
	localparam int WORD_BYTES  = 4;

	typedef enum logic [3:0] {
		CLS_IPV4_OTHER = 4'd0,
		CLS_TCP        = 4'd1,
		CLS_UDP        = 4'd2,
		CLS_ICMPV4     = 4'd3,
		CLS_IGMP       = 4'd4,
		CLS_ICMPV6     = 4'd5,
		CLS_NDP        = 4'd6,
		CLS_MLD        = 4'd7,
		CLS_ARP        = 4'd8,
		CLS_IPV6_OTHER = 4'd9
	} pkt_class_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [15:0] frame_length;
		logic [3:0]  pkt_class;
		logic [63:0] src_addr_high;
		logic [63:0] src_addr_low;
		logic [63:0] dst_addr_high;
		logic [63:0] dst_addr_low;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic        bad_ethertype;
	} out_beat_t;

endpackage

// ===== sv/ehc_capture.sv =====
`include "ethernet_header_classifier_macros.svh"

module ehc_capture
	import ehc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_beat_t  beat,
	output out_beat_t summary
);

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	logic [POSITION_BITS-1:0] pos_q, pos_n;
	logic [47:0] dst_mac_q, dst_mac_n;
	logic [47:0] src_mac_q, src_mac_n;
	logic [15:0] eth_q, eth_n;
	logic [3:0]  ihl_q, ihl_n;
	logic [7:0]  proto_q, proto_n;
	logic [7:0]  icmp6_q, icmp6_n;
	logic [63:0] sa_hi_q, sa_hi_n, sa_lo_q, sa_lo_n;
	logic [63:0] da_hi_q, da_hi_n, da_lo_q, da_lo_n;
	logic [15:0] sport_q, sport_n, dport_q, dport_n;

	logic [POSITION_BITS-1:0] p;
	logic [7:0]  b;
	logic [6:0]  l4;
	logic [POSITION_BITS-1:0] l4_p;
	logic [31:0] len_ext;
	logic        is_v4, is_v6, is_arp;
	pkt_class_t  cls;
	logic        bad;
	logic        ports_ok;

	function automatic logic in_rng(input logic [POSITION_BITS-1:0] pos,
		input int lo, input int hi);
		return (pos >= POSITION_BITS'(lo)) && (pos < POSITION_BITS'(hi));
	endfunction

	assign p = pos_q;
	assign b = beat.frame_byte;
	assign is_v4  = (eth_q == ET_IPV4);
	assign is_v6  = (eth_q == ET_IPV6);
	assign is_arp = (eth_q == ET_ARP);

	// layer 4 offset follows the header length known after this byte
	assign l4   = 7'(ETH_HDR_LEN) + 7'({ihl_n, 2'b00});
	assign l4_p = POSITION_BITS'(l4);

	always_comb begin
		dst_mac_n = dst_mac_q;
		src_mac_n = src_mac_q;
		eth_n     = eth_q;
		ihl_n     = ihl_q;
		proto_n   = proto_q;
		icmp6_n   = icmp6_q;
		sa_hi_n   = sa_hi_q;
		sa_lo_n   = sa_lo_q;
		da_hi_n   = da_hi_q;
		da_lo_n   = da_lo_q;
		sport_n   = sport_q;
		dport_n   = dport_q;
		if (in_rng(p, 0, 6)) begin
			dst_mac_n = {dst_mac_q[39:0], b};
		end else if (in_rng(p, 6, 12)) begin
			src_mac_n = {src_mac_q[39:0], b};
		end else if (in_rng(p, 12, 14)) begin
			eth_n = {eth_q[7:0], b};
		end else if (is_v4) begin
			if (p == POSITION_BITS'(14)) begin
				ihl_n = b[3:0];
			end else if (p == POSITION_BITS'(23)) begin
				proto_n = b;
			end else if (in_rng(p, 26, 30)) begin
				sa_lo_n = {32'h0, sa_lo_q[23:0], b};
			end else if (in_rng(p, 30, 34)) begin
				da_lo_n = {32'h0, da_lo_q[23:0], b};
			end
			if (p >= l4_p && p < l4_p + POSITION_BITS'(2)) begin
				sport_n = {sport_q[7:0], b};
			end else if (p >= l4_p + POSITION_BITS'(2) && p < l4_p + POSITION_BITS'(4)) begin
				dport_n = {dport_q[7:0], b};
			end
		end else if (is_v6) begin
			if (p == POSITION_BITS'(20)) begin
				proto_n = b;
			end else if (in_rng(p, 22, 30)) begin
				sa_hi_n = {sa_hi_q[55:0], b};
			end else if (in_rng(p, 30, 38)) begin
				sa_lo_n = {sa_lo_q[55:0], b};
			end else if (in_rng(p, 38, 46)) begin
				da_hi_n = {da_hi_q[55:0], b};
			end else if (in_rng(p, 46, 54)) begin
				da_lo_n = {da_lo_q[55:0], b};
			end else if (p == POSITION_BITS'(54)) begin
				icmp6_n = b;
			end
		end else if (is_arp) begin
			if (in_rng(p, 28, 32)) begin
				sa_lo_n = {32'h0, sa_lo_q[23:0], b};
			end else if (in_rng(p, 38, 42)) begin
				da_lo_n = {32'h0, da_lo_q[23:0], b};
			end
		end
	end

	assign pos_n = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;

	// classification sees the stores as they stand after this byte
	always_comb begin
		bad = 1'b0;
		cls = CLS_IPV4_OTHER;
		if (eth_n == ET_IPV4) begin
			case (proto_n)
				PROTO_TCP:  cls = CLS_TCP;
				PROTO_UDP:  cls = CLS_UDP;
				PROTO_ICMP: cls = CLS_ICMPV4;
				PROTO_IGMP: cls = CLS_IGMP;
				default:    cls = CLS_IPV4_OTHER;
			endcase
		end else if (eth_n == ET_IPV6) begin
			if (proto_n != PROTO_ICMPV6) begin
				cls = CLS_IPV6_OTHER;
			end else begin
				case (icmp6_n)
					ICMP6_NDP_RS, ICMP6_NDP_RA,
					ICMP6_NDP_NS, ICMP6_NDP_NA:        cls = CLS_NDP;
					ICMP6_MLD_QUERY, ICMP6_MLD_REPORT: cls = CLS_MLD;
					default:                           cls = CLS_ICMPV6;
				endcase
			end
		end else if (eth_n == ET_ARP) begin
			cls = CLS_ARP;
		end else begin
			bad = 1'b1;
		end
	end

	assign ports_ok = (cls == CLS_TCP) || (cls == CLS_UDP);
	assign len_ext  = 32'(pos_n);

	always_comb begin
		summary.dst_mac       = dst_mac_n;
		summary.src_mac       = src_mac_n;
		summary.frame_length  = (len_ext > 32'h0000_FFFF) ? 16'hFFFF : len_ext[15:0];
		summary.pkt_class     = cls;
		summary.src_addr_high = sa_hi_n;
		summary.src_addr_low  = sa_lo_n;
		summary.dst_addr_high = da_hi_n;
		summary.dst_addr_low  = da_lo_n;
		summary.source_port   = ports_ok ? sport_n : 16'h0;
		summary.dest_port     = ports_ok ? dport_n : 16'h0;
		summary.bad_ethertype = bad;
	end

	// everything clears at the end of each frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			dst_mac_q <= '0;
			src_mac_q <= '0;
			eth_q     <= '0;
			ihl_q     <= '0;
			proto_q   <= '0;
			icmp6_q   <= '0;
			sa_hi_q   <= '0;
			sa_lo_q   <= '0;
			da_hi_q   <= '0;
			da_lo_q   <= '0;
			sport_q   <= '0;
			dport_q   <= '0;
		end else if (step) begin
			if (beat.last_byte) begin
				pos_q     <= '0;
				dst_mac_q <= '0;
				src_mac_q <= '0;
				eth_q     <= '0;
				ihl_q     <= '0;
				proto_q   <= '0;
				icmp6_q   <= '0;
				sa_hi_q   <= '0;
				sa_lo_q   <= '0;
				da_hi_q   <= '0;
				da_lo_q   <= '0;
				sport_q   <= '0;
				dport_q   <= '0;
			end else begin
				pos_q     <= pos_n;
				dst_mac_q <= dst_mac_n;
				src_mac_q <= src_mac_n;
				eth_q     <= eth_n;
				ihl_q     <= ihl_n;
				proto_q   <= proto_n;
				icmp6_q   <= icmp6_n;
				sa_hi_q   <= sa_hi_n;
				sa_lo_q   <= sa_lo_n;
				da_hi_q   <= da_hi_n;
				da_lo_q   <= da_lo_n;
				sport_q   <= sport_n;
				dport_q   <= dport_n;
			end
		end
	end

	`EHC_ASSERT_NEXT(a_pos_clears, step && beat.last_byte, pos_q == '0, "position not cleared after last byte")
	`EHC_ASSERT_NOW(a_ports_gated, !ports_ok, summary.source_port == 16'h0 && summary.dest_port == 16'h0, "ports set for a non tcp or udp class")
	`EHC_ASSERT_NOW(a_bad_no_addr, bad, sa_lo_n == 64'h0 && da_lo_n == 64'h0 && cls == CLS_IPV4_OTHER, "bad ethertype with captured addresses")

endmodule

// ===== sv/ethernet_header_classifier.sv =====
// Ethernet header classifier: takes a frame one byte per beat in wire order, with last_byte
// marking the final byte, and returns one summary beat per frame carrying both MACs, the byte
// count (saturating at 65535), a packet class, the IPv4, IPv6 or ARP addresses, the TCP or UDP
// ports over IPv4, and a flag for an ethertype that is none of IPv4, IPv6 or ARP. Fields that a
// short frame does not reach read as zero. A new byte is taken each cycle; the only stall is a
// final byte waiting while a previous summary has not yet been taken. An accepted byte is held
// in the input register; when it moves on, the byte counter and field captures update and, for
// the last byte, the summary is loaded into the result register, which drives summary_valid.
`include "ethernet_header_classifier_macros.svh"

module ethernet_header_classifier
	import ehc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      frame_valid,
	output logic      frame_ready,
	input  in_beat_t  frame,
	output logic      summary_valid,
	input  logic      summary_ready,
	output out_beat_t summary
);

	// input register
	in_beat_t  beat_s1;
	logic      valid_s1;

	// result register
	out_beat_t summary_s2;
	logic      valid_s2;

	// summary built from the stores as updated by the byte in stage 1
	out_beat_t summary_next;

	logic result_free;
	logic advance_s1;
	logic load_s2;

	// the result slot can take a new summary if empty or draining this cycle
	assign result_free = !valid_s2 || summary_ready;

	// a mid-frame byte never waits, a final byte waits for the result slot
	assign advance_s1 = valid_s1 && (!beat_s1.last_byte || result_free);
	assign load_s2    = advance_s1 && beat_s1.last_byte;

	// stage 1 refills whenever it is empty or its beat moves on
	assign frame_ready = !valid_s1 || advance_s1;

	ehc_capture u_capture (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance_s1),
		.beat    (beat_s1),
		.summary (summary_next)
	);

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_ready) begin
			valid_s1 <= frame_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (frame_ready && frame_valid) begin
			beat_s1 <= frame;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (summary_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (load_s2) begin
			summary_s2 <= summary_next;
		end
	end

	assign summary_valid = valid_s2;
	assign summary       = summary_s2;

	`EHC_ASSERT_NOW(a_mid_no_stall, valid_s1 && !beat_s1.last_byte, frame_ready, "mid-frame beat stalled")
	`EHC_ASSERT_NOW(a_last_holds, valid_s1 && beat_s1.last_byte && valid_s2 && !summary_ready, !frame_ready, "last beat overran a pending summary")
	`EHC_ASSERT_NEXT(a_last_gives_summary, valid_s1 && beat_s1.last_byte && frame_ready, summary_valid, "last beat gave no summary")
	`EHC_ASSERT_NOW(a_len_nonzero, summary_valid, summary.frame_length != 16'h0, "summary with zero length")

endmodule
